/* rtl/rectangle_rasterizer_macros.svh */
// Assertion macros for the rectangle rasterizer.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef RECTANGLE_RASTERIZER_MACROS_SVH
`define RECTANGLE_RASTERIZER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RR_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rr_pkg.sv */
// Shared types and constants of the rectangle rasterizer.
// Used by rectangle_rasterizer.sv and the testbench; depends on nothing.
package rr_pkg;

	localparam int MAX_SIDE_DEF  = 512;
	localparam int FRAC_BITS_DEF = 8;

	localparam int FIELD_W   = 20;
	localparam int BND_W     = FIELD_W + 1;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [7:0] KIND_OUTLINE = 8'h72;
	localparam logic [7:0] KIND_FILLED  = 8'h52;

	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_REJECT  = 2'd1;
	localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND    = 2'd2;

	localparam logic [7:0] BACKGROUND_RST = 8'd32;

	typedef struct packed {
		logic [1:0]                op;
		logic [7:0]                shape_kind;
		logic signed [FIELD_W-1:0] rect_x;
		logic signed [FIELD_W-1:0] rect_y;
		logic signed [FIELD_W-1:0] rect_width;
		logic signed [FIELD_W-1:0] rect_height;
		logic [7:0]                paint;
		logic [8:0]                read_col;
		logic [8:0]                read_row;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] cell_value;
	} result_t;

endpackage

/* rtl/rectangle_rasterizer.sv */
// Rectangle rasterizer top level: canvas memory, cell sequencer and bound unit.
// Depends on rr_pkg and rectangle_rasterizer_macros.svh.
//
//  channel | direction | handshake                  | payload
//  item    | in        | item_valid / item_stall    | rr_pkg::item_t
//  result  | out       | result_valid / result_stall| rr_pkg::result_t
//  config  | in        | cfg_write                  | cfg_index, cfg_data
//
// A clear sweeps all 4**ceil(log2(MAX_SIDE)) cells (262144 at MAX_SIDE 512): the canvas
// memory has one write port and the sequencer writes one cell per cycle.
// A draw sweeps used_width * used_height cells; a rejected one and an unused op sweep none.
// A read goes through the registered memory read, which is skipped when it falls outside.
// Reset clears the sequencer and the registers; the canvas holds garbage until a clear.
// A word waiting on a stalled result port does not block acceptance of the next item.
`include "rectangle_rasterizer_macros.svh"

module rectangle_rasterizer #(
	parameter int MAX_SIDE  = rr_pkg::MAX_SIDE_DEF,
	parameter int FRAC_BITS = rr_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  rr_pkg::item_t                  item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output rr_pkg::result_t                result,
	input  logic                           cfg_write,
	input  logic [rr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rr_pkg::CFG_W-1:0]       cfg_data
);
	import rr_pkg::*;

	localparam int CW     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int SW     = CW + 1;
	localparam int ADDR_W = 2 * CW;
	localparam int DEPTH  = 1 << ADDR_W;

	localparam logic signed [BND_W-1:0] UNIT_M1 = BND_W'((1 << FRAC_BITS) - 1);
	localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_CLEAR     = 3'd1;
	localparam logic [2:0] ST_SETUP_X   = 3'd2;
	localparam logic [2:0] ST_SETUP_Y   = 3'd3;
	localparam logic [2:0] ST_DRAW      = 3'd4;
	localparam logic [2:0] ST_READ      = 3'd5;
	localparam logic [2:0] ST_READ_DATA = 3'd6;
	localparam logic [2:0] ST_FINISH    = 3'd7;

	logic [2:0]        state_q;
	logic [CW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic              result_valid_q;
	result_t           result_q;

	logic [CFG_W-1:0]  canvas_width_q;
	logic [CFG_W-1:0]  canvas_height_q;
	logic [7:0]        background_q;

	item_t             item_q;
	logic              filled_q;
	logic signed [BND_W-1:0] col_lo_q;
	logic signed [BND_W-1:0] col_hi_q;
	logic signed [BND_W-1:0] row_lo_q;
	logic signed [BND_W-1:0] row_hi_q;
	logic [1:0]        res_status_q;
	logic [7:0]        res_value_q;

	logic [7:0]        canvas_mem [DEPTH];
	logic [7:0]        rd_data_q;

	logic              accept;
	logic              out_free;
	logic [SW-1:0]     used_w;
	logic [SW-1:0]     used_h;
	logic              col_last;
	logic              row_last;
	logic              sweep_last;
	logic              reject;
	logic              outside;

	logic signed [FIELD_W-1:0] opnd_a;
	logic signed [FIELD_W-1:0] opnd_b;
	logic signed [BND_W-1:0]   edge_sum;
	logic signed [FIELD_W-1:0] edge_sat;
	logic signed [BND_W-1:0]   lo_sum;
	logic signed [BND_W-1:0]   lo_bnd;
	logic signed [BND_W-1:0]   hi_bnd;

	logic signed [BND_W-1:0]   col_s;
	logic signed [BND_W-1:0]   row_s;
	logic              covered;
	logic              border;
	logic              mem_we;
	logic [7:0]        mem_wdata;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign used_w = (32'(canvas_width_q) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(canvas_width_q);
	assign used_h = (32'(canvas_height_q) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(canvas_height_q);

	assign col_last   = (SW'(col_q) + SW'(1)) == used_w;
	assign row_last   = (SW'(row_q) + SW'(1)) == used_h;
	assign sweep_last = &{row_q, col_q};

	assign reject = item_q.rect_width[FIELD_W-1] || (item_q.rect_width == '0) ||
		item_q.rect_height[FIELD_W-1] || (item_q.rect_height == '0) ||
		!(item_q.shape_kind inside {KIND_OUTLINE, KIND_FILLED});

	assign outside = (32'(item_q.read_col) >= 32'(used_w)) ||
		(32'(item_q.read_row) >= 32'(used_h));

	// Shared bound unit. A cell corner c*unit lies inside [a, a+b] exactly when
	// ceil(a/unit) <= c <= floor(sat(a+b)/unit), and it is a border cell exactly when
	// it sits on one of those two bounds.
	always_comb begin
		if (state_q == ST_SETUP_Y) begin
			opnd_a = item_q.rect_y;
			opnd_b = item_q.rect_height;
		end else begin
			opnd_a = item_q.rect_x;
			opnd_b = item_q.rect_width;
		end
		edge_sum = BND_W'(opnd_a) + BND_W'(opnd_b);
		if (edge_sum[BND_W-1] != edge_sum[BND_W-2]) begin
			edge_sat = edge_sum[BND_W-1] ? FIELD_MIN : FIELD_MAX;
		end else begin
			edge_sat = edge_sum[FIELD_W-1:0];
		end
		lo_sum = BND_W'(opnd_a) + UNIT_M1;
		lo_bnd = lo_sum >>> FRAC_BITS;
		hi_bnd = BND_W'(edge_sat) >>> FRAC_BITS;
	end

	assign col_s   = signed'(BND_W'(col_q));
	assign row_s   = signed'(BND_W'(row_q));
	assign covered = (col_s >= col_lo_q) && (col_s <= col_hi_q) &&
		(row_s >= row_lo_q) && (row_s <= row_hi_q);
	assign border  = (col_s == col_lo_q) || (col_s == col_hi_q) ||
		(row_s == row_lo_q) || (row_s == row_hi_q);

	assign mem_we    = (state_q == ST_CLEAR) ||
		((state_q == ST_DRAW) && covered && (filled_q || border));
	assign mem_wdata = (state_q == ST_CLEAR) ? background_q : item_q.paint;
	assign wr_addr   = {row_q, col_q};
	assign rd_addr   = {CW'(item_q.read_row), CW'(item_q.read_col)};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			canvas_mem[wr_addr] <= mem_wdata;
		end
		rd_data_q <= canvas_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q  <= '0;
			canvas_height_q <= '0;
			background_q    <= BACKGROUND_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data;
				REG_CANVAS_HEIGHT: canvas_height_q <= cfg_data;
				REG_BACKGROUND:    background_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			row_q          <= '0;
			col_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						row_q <= '0;
						col_q <= '0;
						case (item.op)
							OP_CLEAR: state_q <= ST_CLEAR;
							OP_DRAW:  state_q <= ST_SETUP_X;
							OP_READ:  state_q <= ST_READ;
							default:  state_q <= ST_FINISH;
						endcase
					end
				end
				ST_CLEAR: begin
					{row_q, col_q} <= {row_q, col_q} + ADDR_W'(1);
					if (sweep_last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_SETUP_X: begin
					state_q <= reject ? ST_FINISH : ST_SETUP_Y;
				end
				ST_SETUP_Y: begin
					if ((used_w == '0) || (used_h == '0)) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_DRAW;
					end
				end
				ST_DRAW: begin
					if (col_last) begin
						col_q <= '0;
						if (row_last) begin
							state_q <= ST_FINISH;
						end else begin
							row_q <= row_q + CW'(1);
						end
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				ST_READ: begin
					state_q <= outside ? ST_FINISH : ST_READ_DATA;
				end
				ST_READ_DATA: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_q       <= item;
					res_status_q <= STATUS_DONE;
					res_value_q  <= '0;
				end
			end
			ST_SETUP_X: begin
				col_lo_q <= lo_bnd;
				col_hi_q <= hi_bnd;
				filled_q <= (item_q.shape_kind == KIND_FILLED);
				if (reject) begin
					res_status_q <= STATUS_REJECT;
				end
			end
			ST_SETUP_Y: begin
				row_lo_q <= lo_bnd;
				row_hi_q <= hi_bnd;
			end
			ST_READ: begin
				if (outside) begin
					res_status_q <= STATUS_OUTSIDE;
				end
			end
			ST_READ_DATA: begin
				res_value_q <= rd_data_q;
			end
			ST_FINISH: begin
				if (out_free) begin
					result_q.status     <= res_status_q;
					result_q.cell_value <= res_value_q;
				end
			end
			default: ;
		endcase
	end

	`RR_ASSERT_IMP(a_write_only_in_sweep, clk, arst_n, mem_we,
		(state_q == ST_CLEAR) || (state_q == ST_DRAW), "canvas written outside a sweep")
	`RR_ASSERT_IMP(a_draw_inside_canvas, clk, arst_n, (state_q == ST_DRAW) && mem_we,
		(SW'(col_q) < used_w) && (SW'(row_q) < used_h), "draw wrote outside the canvas")
	`RR_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, accept,
		state_q != ST_IDLE, "accepted word did not start work")
	`RR_ASSERT_NXT(a_finish_delivers, clk, arst_n, (state_q == ST_FINISH) && out_free,
		result_valid_q && (state_q == ST_IDLE), "finished item gave no result word")
	`RR_ASSERT_NXT(a_reject_status, clk, arst_n, (state_q == ST_SETUP_X) && reject,
		(state_q == ST_FINISH) && (res_status_q == STATUS_REJECT), "rejected rectangle drawn")

endmodule

/* tb/tb_rectangle_rasterizer.sv */
// Self-checking testbench for rectangle_rasterizer: sends clear, draw and read words,
// predicts each result word from its own canvas copy and compares them in order.
// Depends on rr_pkg and the rectangle_rasterizer RTL.
module tb_rectangle_rasterizer;
	timeunit 1ns;
	timeprecision 1ps;
	import rr_pkg::*;

	localparam int SIDE = MAX_SIDE_DEF;
	localparam int FRAC = FRAC_BITS_DEF;
	localparam int UNIT = 1 << FRAC;
	localparam longint COORD_MAX = (longint'(1) << (FIELD_W - 1)) - 1;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// Predicted block state.
	logic [7:0] canvas_copy [SIDE*SIDE];
	logic [CFG_W-1:0] width_reg = '0;
	logic [CFG_W-1:0] height_reg = '0;
	logic [7:0] background_reg = BACKGROUND_RST;
	result_t awaited_results [$];

	bit steady = 1'b0;
	int unsigned hold_asked = 0;
	int unsigned hold_given = 0;
	int unsigned hold_left = 0;

	int mismatches = 0;
	int compared = 0;
	int clears = 0;
	int draws = 0;
	int rejects = 0;
	int reads = 0;
	int outside = 0;
	int unused = 0;
	int settings = 0;

	rectangle_rasterizer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int used_span(input logic [CFG_W-1:0] v);
		return (v > SIDE) ? SIDE : int'(v);
	endfunction

	// Applies one item to the canvas copy and returns the word the block should produce.
	function automatic result_t rasterize_item(input item_t it);
		result_t res;
		longint x0, y0, rw, rh, x1, y1, px, py;
		int cols, rows;
		bit border;
		res = '0;
		cols = used_span(width_reg);
		rows = used_span(height_reg);
		case (it.op)
		OP_CLEAR: begin
			clears++;
			for (int i = 0; i < SIDE * SIDE; i++)
				canvas_copy[i] = background_reg;
		end
		OP_DRAW: begin
			draws++;
			x0 = it.rect_x;
			y0 = it.rect_y;
			rw = it.rect_width;
			rh = it.rect_height;
			if (rw <= 0 || rh <= 0 ||
					(it.shape_kind != KIND_OUTLINE && it.shape_kind != KIND_FILLED)) begin
				rejects++;
				res.status = STATUS_REJECT;
			end else begin
				// Sizes are positive here, so only the upper end can overflow.
				x1 = (x0 + rw > COORD_MAX) ? COORD_MAX : x0 + rw;
				y1 = (y0 + rh > COORD_MAX) ? COORD_MAX : y0 + rh;
				for (int r = 0; r < rows; r++) begin
					for (int c = 0; c < cols; c++) begin
						px = longint'(c) * UNIT;
						py = longint'(r) * UNIT;
						if (px >= x0 && px <= x1 && py >= y0 && py <= y1) begin
							border = (px - x0 < UNIT) || (x1 - px < UNIT) ||
								(py - y0 < UNIT) || (y1 - py < UNIT);
							if (it.shape_kind == KIND_FILLED || border)
								canvas_copy[r * SIDE + c] = it.paint;
						end
					end
				end
			end
		end
		OP_READ: begin
			reads++;
			if (it.read_col >= cols || it.read_row >= rows) begin
				outside++;
				res.status = STATUS_OUTSIDE;
			end else begin
				res.cell_value = canvas_copy[it.read_row * SIDE + it.read_col];
			end
		end
		default: begin
			unused++;
		end
		endcase
		return res;
	endfunction

	function automatic item_t draw_item(input logic [7:0] kind, input int x, input int y,
			input int w, input int h, input logic [7:0] colour);
		item_t it;
		it = '0;
		it.op = OP_DRAW;
		it.shape_kind = kind;
		it.rect_x = x[FIELD_W-1:0];
		it.rect_y = y[FIELD_W-1:0];
		it.rect_width = w[FIELD_W-1:0];
		it.rect_height = h[FIELD_W-1:0];
		it.paint = colour;
		return it;
	endfunction

	function automatic item_t read_item(input int col, input int row);
		item_t it;
		it = '0;
		it.op = OP_READ;
		it.read_col = col[8:0];
		it.read_row = row[8:0];
		return it;
	endfunction

	function automatic item_t plain_item(input logic [1:0] op);
		item_t it;
		it = '0;
		it.op = op;
		return it;
	endfunction

	// Mostly well-formed draws and reads near the canvas, the rest broken, full-range or unused ops.
	function automatic item_t random_item(input int cols, input int rows);
		item_t it;
		logic [127:0] noise;
		int roll, v;
		noise = {$urandom, $urandom, $urandom, $urandom};
		it = noise[$bits(item_t)-1:0];
		roll = $urandom_range(99);
		if (roll < 50) begin
			it.op = OP_DRAW;
			it.shape_kind = $urandom_range(1) ? KIND_OUTLINE : KIND_FILLED;
			v = int'($urandom_range((cols + 6) * UNIT)) - 3 * UNIT;
			it.rect_x = v[FIELD_W-1:0];
			v = int'($urandom_range((rows + 6) * UNIT)) - 3 * UNIT;
			it.rect_y = v[FIELD_W-1:0];
			v = int'($urandom_range(1, (cols + 2) * UNIT));
			it.rect_width = v[FIELD_W-1:0];
			v = int'($urandom_range(1, (rows + 2) * UNIT));
			it.rect_height = v[FIELD_W-1:0];
			if ($urandom_range(1)) begin
				// Whole-unit edges land exactly on cell corners.
				it.rect_x[FRAC-1:0] = '0;
				it.rect_y[FRAC-1:0] = '0;
				it.rect_width[FRAC-1:0] = '0;
				it.rect_height[FRAC-1:0] = '0;
			end
		end else if (roll < 58) begin
			it.op = OP_DRAW;
			case ($urandom_range(2))
			0: begin
				if (it.shape_kind == KIND_OUTLINE || it.shape_kind == KIND_FILLED)
					it.shape_kind ^= 8'h01;
			end
			1: begin
				it.shape_kind = KIND_OUTLINE;
				v = -int'($urandom_range(1 << (FIELD_W - 1)));
				it.rect_width = v[FIELD_W-1:0];
			end
			default: begin
				it.shape_kind = KIND_FILLED;
				v = -int'($urandom_range(1 << (FIELD_W - 1)));
				it.rect_height = v[FIELD_W-1:0];
			end
			endcase
		end else if (roll < 62) begin
			it.op = OP_DRAW;
			it.shape_kind = $urandom_range(1) ? KIND_OUTLINE : KIND_FILLED;
		end else if (roll < 95) begin
			it.op = OP_READ;
			if ($urandom_range(9) != 0) begin
				it.read_col = 9'($urandom_range(cols > 511 ? 511 : cols));
				it.read_row = 9'($urandom_range(rows > 511 ? 511 : rows));
			end
		end else begin
			it.op = OP_UNUSED;
		end
		return it;
	endfunction

	task automatic set_canvas(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input logic [CFG_W-1:0] bg);
		cfg_write <= 1'b1;
		cfg_index <= REG_CANVAS_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_CANVAS_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_index <= REG_BACKGROUND;
		cfg_data <= bg;
		@(posedge clk);
		cfg_write <= 1'b0;
		width_reg = w;
		height_reg = h;
		background_reg = bg[7:0];
		settings++;
		@(posedge clk);
	endtask

	task automatic send_item(input item_t it);
		while (!steady && $urandom_range(99) < 23) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		awaited_results.push_back(rasterize_item(it));
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_state();
		// With the reset canvas size of zero every read falls outside.
		send_item(read_item(0, 0));
		send_item(draw_item(KIND_FILLED, 0, 0, 4 * UNIT, 4 * UNIT, 8'hAA));
		send_item(plain_item(OP_UNUSED));
		// This clear uses the background value left by reset.
		send_item(plain_item(OP_CLEAR));
		drain();
	endtask

	task automatic test_shapes();
		set_canvas(10'd16, 10'd12, CFG_W'(BACKGROUND_RST));
		send_item(draw_item(KIND_FILLED, 2 * UNIT + UNIT / 2, UNIT, 5 * UNIT, 4 * UNIT, 8'h11));
		send_item(draw_item(KIND_OUTLINE, 8 * UNIT, 2 * UNIT, 6 * UNIT, 6 * UNIT, 8'hEE));
		// The right edge saturates at the top of the coordinate range.
		send_item(draw_item(KIND_OUTLINE, 3 * UNIT, 5 * UNIT, int'(COORD_MAX), 2 * UNIT,
			8'h3C));
		send_item(draw_item(KIND_FILLED, 12 * UNIT, 10 * UNIT, 1, 1, 8'h81));
		send_item(read_item(3, 1));
		send_item(read_item(7, 5));
		send_item(read_item(8, 5));
		send_item(read_item(11, 5));
		send_item(read_item(14, 8));
		send_item(read_item(3, 6));
		send_item(read_item(15, 7));
		send_item(read_item(12, 10));
		send_item(read_item(16, 0));
		drain();
	endtask

	task automatic test_rejects();
		send_item(draw_item(KIND_FILLED, 0, 0, 0, 4 * UNIT, 8'hFF));
		send_item(draw_item(KIND_OUTLINE, 0, 0, 4 * UNIT, -(1 << (FIELD_W - 1)), 8'hFF));
		send_item(draw_item(8'h00, 0, 0, 8 * UNIT, 8 * UNIT, 8'hFF));
		send_item(draw_item(8'hFF, 0, 0, 8 * UNIT, 8 * UNIT, 8'hFF));
		send_item(read_item(3, 1));
		drain();
	endtask

	task automatic test_oversized_canvas();
		set_canvas(10'h3FF, 10'd2, CFG_W'(BACKGROUND_RST));
		send_item(draw_item(KIND_FILLED, 500 * UNIT, 0, 20 * UNIT, UNIT + UNIT / 2, 8'h5C));
		send_item(read_item(511, 1));
		send_item(read_item(499, 0));
		drain();
	endtask

	task automatic test_background_clear();
		set_canvas(10'd5, 10'd5, 10'h0FF);
		send_item(plain_item(OP_CLEAR));
		send_item(read_item(4, 4));
		drain();
	endtask

	task automatic test_backpressure();
		set_canvas(10'd8, 10'd8, CFG_W'(BACKGROUND_RST));
		// The receiver holds off while words keep coming, so the input must stall.
		hold_asked <= hold_asked + 1;
		steady <= 1'b1;
		for (int n = 0; n < 10; n++)
			send_item(random_item(8, 8));
		drain();
		steady <= 1'b0;
		for (int n = 0; n < 5; n++)
			send_item(random_item(8, 8));
		drain();
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
			0: set_canvas(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(1, 40)),
				CFG_W'($urandom_range(1023)));
			1: begin
				set_canvas(CFG_W'($urandom_range(1, 24)), CFG_W'($urandom_range(1, 24)),
					CFG_W'($urandom_range(1023)));
				steady <= 1'b1;
			end
			2: set_canvas(10'd0, 10'd512, CFG_W'($urandom_range(1023)));
			3: set_canvas(CFG_W'($urandom_range(1) ? 512 : $urandom_range(513, 1023)),
				CFG_W'($urandom_range(1, 3)), CFG_W'($urandom_range(1023)));
			default: set_canvas(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(513, 1023)),
				CFG_W'($urandom_range(1023)));
			endcase
			for (int n = 0; n < 12; n++)
				send_item(random_item(used_span(width_reg), used_span(height_reg)));
			drain();
			steady <= 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_given != hold_asked) begin
			result_stall <= 1'b1;
			hold_given <= hold_given + 1;
			hold_left <= HOLD_CYCLES - 1;
		end else begin
			result_stall <= !steady && ($urandom_range(99) < 23);
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result word status %0d value %0h arrived with none expected",
					$time, result.status, result.cell_value);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				compared++;
				if (result.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.status, result.status);
					mismatches++;
				end
				if (result.cell_value !== want.cell_value) begin
					$display("%0t: cell_value mismatch, expected %0h, actual %0h",
						$time, want.cell_value, result.cell_value);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_shapes();
		test_rejects();
		test_oversized_canvas();
		test_background_clear();
		test_backpressure();
		test_random_phases();
		drain();
		$display("Run covered %0d clears, %0d draws (%0d rejected), %0d reads (%0d outside)",
			clears, draws, rejects, reads, outside);
		$display("and %0d unused-op words over %0d canvas settings; %0d words compared.",
			unused, settings, compared);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#(120_000_000);
		$display("%0t: timeout with %0d words still expected", $time, awaited_results.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
